// ----- rtl/pss_pkg.sv -----
// package: constants, types and state codes shared by the path substitution stream
`timescale 1ns / 1ps
package pss_pkg;

    localparam int PATH_MAX_BYTES = 32;
    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 6;
    localparam int IDX_W          = 5;
    localparam int WIN_IDX_W      = $clog2(PATH_MAX_BYTES);
    localparam int FILL_W         = $clog2(PATH_MAX_BYTES + 1);

    localparam int APB_AW         = 4;
    localparam int APB_DW         = 32;
    localparam int REG_IDX_W      = APB_AW - 2;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_DATA     = 2'd0;
    localparam logic [1:0] OP_LOAD_OLD = 2'd1;
    localparam logic [1:0] OP_LOAD_NEW = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_BINARY_MODE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_OLD_LENGTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_NEW_LENGTH  = 2'd2;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_LOAD_OLD,
        KIND_LOAD_NEW
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  value;
        logic [IDX_W-1:0]   index;
        logic               last;
    } item_t;

    typedef struct packed {
        logic               binary;
        logic               err;
        logic [LEN_W-1:0]   olen;
        logic [LEN_W-1:0]   nlen;
        logic [LEN_W-1:0]   pad;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               run_last;
        logic               stream_end;
        logic               config_error;
    } result_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_MATCH,
        ENG_NEWP,
        ENG_DRAIN,
        ENG_PAD
    } eng_state_t;

endpackage

// ----- rtl/pss_front.sv -----
// front end: accepts input requests, decodes the opcode and queues items for the engine
`timescale 1ns / 1ps
module pss_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  opcode,
    input  logic [pss_pkg::BYTE_W-1:0]  value_byte,
    input  logic [pss_pkg::IDX_W-1:0]   pattern_index,
    input  logic                        stream_last,
    output logic                        q_valid,
    output pss_pkg::item_t              q_item,
    input  logic                        q_pop
);
    import pss_pkg::*;

    item_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               accept;
    logic               keep;
    logic               wr_en;
    logic               take;
    logic               idx_ok;
    item_t              item_in;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept  = push && !full;
    assign idx_ok  = (int'(pattern_index) < PATH_MAX_BYTES);
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign take    = q_pop && q_valid;
    assign wr_en   = accept && keep;

    // unused opcodes and out of range loads are accepted and dropped here
    always_comb
    begin : classify
        item_in.value = value_byte;
        item_in.index = pattern_index;
        item_in.last  = stream_last;
        item_in.kind  = KIND_DATA;
        keep          = 1'b0;
        case (opcode)
            OP_DATA:
            begin
                item_in.kind = KIND_DATA;
                keep         = 1'b1;
            end
            OP_LOAD_OLD:
            begin
                item_in.kind = KIND_LOAD_OLD;
                keep         = idx_ok;
            end
            OP_LOAD_NEW:
            begin
                item_in.kind = KIND_LOAD_NEW;
                keep         = idx_ok;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin : queue_ctrl
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr_en, take})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ----- rtl/pss_engine.sv -----
// back end: pattern store, match window scan and the result byte sequencer
`timescale 1ns / 1ps
module pss_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  pss_pkg::cfg_t       cfg,
    input  logic                cfg_clr,
    input  logic                q_valid,
    input  pss_pkg::item_t      q_item,
    output logic                q_pop,
    input  logic                rq_room,
    output logic                rq_push,
    output pss_pkg::result_t    rq_data
);
    import pss_pkg::*;

    logic [BYTE_W-1:0]  old_pat_reg [PATH_MAX_BYTES];
    logic [BYTE_W-1:0]  new_pat_reg [PATH_MAX_BYTES];
    logic [BYTE_W-1:0]  win_reg     [PATH_MAX_BYTES];

    eng_state_t         state_reg;
    eng_state_t         state_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic               suffix_reg;
    logic               suffix_next;
    logic [LEN_W-1:0]   cnt_reg;
    logic [LEN_W-1:0]   cnt_next;
    logic               last_reg;
    logic               last_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [BYTE_W-1:0]  pend_byte_reg;
    logic [BYTE_W-1:0]  pend_byte_next;

    logic               emit;
    logic [BYTE_W-1:0]  emit_byte;
    logic               finish;
    logic               win_append;
    logic               win_shift;
    logic               old_we;
    logic               new_we;
    logic               win_ok;
    logic [LEN_W-1:0]   pad_nul;
    logic [LEN_W-1:0]   pad_cap;

    assign pad_nul = cfg.pad + 1'b1;
    // one result slot of the step goes to the byte itself
    assign pad_cap = (cfg.pad >= LEN_W'(PATH_MAX_BYTES)) ? LEN_W'(PATH_MAX_BYTES) : pad_nul;

    // held bytes still form a prefix of the old path
    always_comb
    begin : window_cmp
        win_ok = 1'b1;
        for (int j = 0; j < PATH_MAX_BYTES; j++)
        begin
            if ((FILL_W'(j) < fill_reg) && (win_reg[j] != old_pat_reg[j]))
            begin
                win_ok = 1'b0;
            end
        end
    end

    always_comb
    begin : seq
        state_next  = state_reg;
        fill_next   = fill_reg;
        suffix_next = suffix_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        q_pop       = 1'b0;
        emit        = 1'b0;
        emit_byte   = '0;
        finish      = 1'b0;
        win_append  = 1'b0;
        win_shift   = 1'b0;
        old_we      = 1'b0;
        new_we      = 1'b0;
        case (state_reg)
            ENG_IDLE:
            begin
                if (q_valid && rq_room)
                begin
                    q_pop = 1'b1;
                    case (q_item.kind)
                        KIND_LOAD_OLD: old_we = 1'b1;
                        KIND_LOAD_NEW: new_we = 1'b1;
                        KIND_DATA:
                        begin
                            last_next = q_item.last;
                            if (cfg.err)
                            begin
                                // byte joins the window, then everything drains unchanged
                                win_append  = 1'b1;
                                fill_next   = fill_reg + 1'b1;
                                suffix_next = 1'b0;
                                state_next  = ENG_DRAIN;
                            end
                            else if (cfg.binary && suffix_reg)
                            begin
                                emit       = 1'b1;
                                emit_byte  = q_item.value;
                                state_next = ENG_PAD;
                                if (q_item.value == '0)
                                begin
                                    cnt_next    = cfg.pad;
                                    suffix_next = 1'b0;
                                end
                                else if (q_item.last)
                                begin
                                    // terminating nul plus padding
                                    cnt_next    = pad_cap;
                                    suffix_next = 1'b0;
                                end
                                else
                                begin
                                    cnt_next = '0;
                                end
                            end
                            else
                            begin
                                win_append = 1'b1;
                                fill_next  = fill_reg + 1'b1;
                                state_next = ENG_MATCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ENG_MATCH:
            begin
                if (rq_room)
                begin
                    if (win_ok && (fill_reg == FILL_W'(cfg.olen)))
                    begin
                        fill_next   = '0;
                        suffix_next = cfg.binary;
                        cnt_next    = '0;
                        state_next  = ENG_NEWP;
                    end
                    else if (win_ok)
                    begin
                        if (last_reg)
                        begin
                            state_next = ENG_DRAIN;
                        end
                        else
                        begin
                            finish     = 1'b1;
                            state_next = ENG_IDLE;
                        end
                    end
                    else
                    begin
                        // oldest held byte can no longer start a match
                        emit      = 1'b1;
                        emit_byte = win_reg[0];
                        win_shift = 1'b1;
                        fill_next = fill_reg - 1'b1;
                    end
                end
            end
            ENG_NEWP:
            begin
                if (rq_room)
                begin
                    if (cnt_reg != cfg.nlen)
                    begin
                        emit      = 1'b1;
                        emit_byte = new_pat_reg[cnt_reg[WIN_IDX_W-1:0]];
                        cnt_next  = cnt_reg + 1'b1;
                    end
                    else if (last_reg && cfg.binary)
                    begin
                        cnt_next    = pad_nul;
                        suffix_next = 1'b0;
                        state_next  = ENG_PAD;
                    end
                    else
                    begin
                        finish     = 1'b1;
                        state_next = ENG_IDLE;
                        if (last_reg)
                        begin
                            suffix_next = 1'b0;
                        end
                    end
                end
            end
            ENG_DRAIN:
            begin
                if (rq_room)
                begin
                    if (fill_reg != '0)
                    begin
                        emit      = 1'b1;
                        emit_byte = win_reg[0];
                        win_shift = 1'b1;
                        fill_next = fill_reg - 1'b1;
                    end
                    else
                    begin
                        finish      = 1'b1;
                        suffix_next = 1'b0;
                        state_next  = ENG_IDLE;
                    end
                end
            end
            ENG_PAD:
            begin
                if (rq_room)
                begin
                    if (cnt_reg != '0)
                    begin
                        emit      = 1'b1;
                        emit_byte = '0;
                        cnt_next  = cnt_reg - 1'b1;
                    end
                    else
                    begin
                        finish     = 1'b1;
                        state_next = ENG_IDLE;
                        if (last_reg)
                        begin
                            suffix_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
        if (cfg_clr)
        begin
            fill_next   = '0;
            suffix_next = 1'b0;
        end
    end

    // newest byte is held until the next byte or the finish so the last byte of a request can be marked
    always_comb
    begin : pend
        pend_valid_next      = pend_valid_reg;
        pend_byte_next       = pend_byte_reg;
        rq_push              = 1'b0;
        rq_data.data         = pend_byte_reg;
        rq_data.run_last     = 1'b0;
        rq_data.stream_end   = 1'b0;
        rq_data.config_error = cfg.err;
        if (emit)
        begin
            rq_push         = pend_valid_reg;
            pend_valid_next = 1'b1;
            pend_byte_next  = emit_byte;
        end
        else if (finish)
        begin
            rq_push            = pend_valid_reg;
            rq_data.run_last   = 1'b1;
            rq_data.stream_end = last_reg;
            pend_valid_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ENG_IDLE;
            fill_reg       <= '0;
            suffix_reg     <= 1'b0;
            cnt_reg        <= '0;
            last_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            suffix_reg     <= suffix_next;
            cnt_reg        <= cnt_next;
            last_reg       <= last_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        if (old_we)
        begin
            old_pat_reg[q_item.index] <= q_item.value;
        end
        if (new_we)
        begin
            new_pat_reg[q_item.index] <= q_item.value;
        end
        if (win_shift)
        begin
            for (int j = 0; j < PATH_MAX_BYTES - 1; j++)
            begin
                win_reg[j] <= win_reg[j+1];
            end
        end
        if (win_append)
        begin
            win_reg[fill_reg[WIN_IDX_W-1:0]] <= q_item.value;
        end
    end

endmodule

// ----- rtl/pss_outq.sv -----
// result queue: holds finished result bytes until the consumer pops them
`timescale 1ns / 1ps
module pss_outq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  pss_pkg::result_t            wr_data,
    output logic                        room,
    output logic                        empty,
    input  logic                        pop,
    output logic [pss_pkg::BYTE_W-1:0]  out_byte,
    output logic                        run_last,
    output logic                        stream_end,
    output logic                        config_error
);
    import pss_pkg::*;

    result_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               put;
    logic               take;
    result_t            head;

    assign room         = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign empty        = (count_reg == '0);
    assign put          = wr_en && room;
    assign take         = pop && !empty;
    assign head         = slot_reg[rd_ptr_reg];
    assign out_byte     = head.data;
    assign run_last     = head.run_last;
    assign stream_end   = head.stream_end;
    assign config_error = head.config_error;

    always_comb
    begin : queue_ctrl
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (put)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({put, take})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (put)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/path_string_substitution_stream_top.sv -----
// top level: register port, length clamping and the front, engine and result queue
`timescale 1ns / 1ps
// Streaming path substitution. Data bytes enter through a two-entry request queue and
// leave through a two-entry result queue, so input and output stall independently. The
// old and new paths are loaded with load opcodes and go through the same queue as the
// data, so a load only affects later bytes. The engine handles one request at a time
// with one window step or one result byte per cycle while the result queue has room: a
// byte that breaks the match releases held bytes one by one, a completed match emits
// new_length bytes of the new path, and a padding run emits its zero bytes. Register
// writes (binary_mode at 0x0, old_length at 0x4, new_length at 0x8) drop held bytes
// and must only happen while the block is drained. With binary_mode set and new_length
// above old_length the stream passes unchanged and every result carries config_error.
module path_string_substitution_stream_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pss_pkg::APB_AW-1:0]  paddr,
    input  logic [pss_pkg::APB_DW-1:0]  pwdata,
    output logic [pss_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  opcode,
    input  logic [pss_pkg::BYTE_W-1:0]  value_byte,
    input  logic [pss_pkg::IDX_W-1:0]   pattern_index,
    input  logic                        stream_last,
    output logic                        empty,
    input  logic                        pop,
    output logic [pss_pkg::BYTE_W-1:0]  out_byte,
    output logic                        run_last,
    output logic                        stream_end,
    output logic                        config_error
);
    import pss_pkg::*;

    logic                   binary_mode_reg;
    logic                   binary_mode_next;
    logic [LEN_W-1:0]       old_length_reg;
    logic [LEN_W-1:0]       old_length_next;
    logic [LEN_W-1:0]       new_length_reg;
    logic [LEN_W-1:0]       new_length_next;
    logic [REG_IDX_W-1:0]   cfg_index;
    logic                   cfg_wr;
    logic                   cfg_clr;
    cfg_t                   cfg;

    item_t                  q_item;
    logic                   q_valid;
    logic                   q_pop;
    logic                   rq_room;
    logic                   rq_push;
    result_t                rq_data;

    assign pready    = 1'b1;
    assign cfg_index = paddr[APB_AW-1:2];
    assign cfg_wr    = psel && penable && pwrite && pready;

    always_comb
    begin : reg_write
        binary_mode_next = binary_mode_reg;
        old_length_next  = old_length_reg;
        new_length_next  = new_length_reg;
        cfg_clr          = 1'b0;
        if (cfg_wr)
        begin
            case (cfg_index)
                REG_BINARY_MODE:
                begin
                    binary_mode_next = pwdata[0];
                    cfg_clr          = 1'b1;
                end
                REG_OLD_LENGTH:
                begin
                    old_length_next = pwdata[LEN_W-1:0];
                    cfg_clr         = 1'b1;
                end
                REG_NEW_LENGTH:
                begin
                    new_length_next = pwdata[LEN_W-1:0];
                    cfg_clr         = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin : reg_read
        case (cfg_index)
            REG_BINARY_MODE: prdata = APB_DW'(binary_mode_reg);
            REG_OLD_LENGTH:  prdata = APB_DW'(old_length_reg);
            REG_NEW_LENGTH:  prdata = APB_DW'(new_length_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binary_mode_reg <= 1'b0;
            old_length_reg  <= LEN_W'(1);
            new_length_reg  <= '0;
        end
        else
        begin
            binary_mode_reg <= binary_mode_next;
            old_length_reg  <= old_length_next;
            new_length_reg  <= new_length_next;
        end
    end

    // lengths clamped to the path store size, old path at least one byte
    always_comb
    begin : cfg_derive
        cfg.binary = binary_mode_reg;
        if (old_length_reg == '0)
        begin
            cfg.olen = LEN_W'(1);
        end
        else if (old_length_reg > LEN_W'(PATH_MAX_BYTES))
        begin
            cfg.olen = LEN_W'(PATH_MAX_BYTES);
        end
        else
        begin
            cfg.olen = old_length_reg;
        end
        if (new_length_reg > LEN_W'(PATH_MAX_BYTES))
        begin
            cfg.nlen = LEN_W'(PATH_MAX_BYTES);
        end
        else
        begin
            cfg.nlen = new_length_reg;
        end
        cfg.err = binary_mode_reg && (cfg.nlen > cfg.olen);
        cfg.pad = cfg.olen - cfg.nlen;
    end

    pss_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .value_byte    (value_byte),
        .pattern_index (pattern_index),
        .stream_last   (stream_last),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    pss_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_clr (cfg_clr),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .rq_room (rq_room),
        .rq_push (rq_push),
        .rq_data (rq_data)
    );

    pss_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (rq_push),
        .wr_data      (rq_data),
        .room         (rq_room),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .stream_end   (stream_end),
        .config_error (config_error)
    );

endmodule

// ----- rtl/pss_checker.sv -----
// checker: port level properties of the path substitution stream, bound to the top level
`timescale 1ns / 1ps
module pss_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [pss_pkg::APB_AW-1:0]  paddr,
    input logic [pss_pkg::APB_DW-1:0]  pwdata,
    input logic [pss_pkg::APB_DW-1:0]  prdata,
    input logic                        pready,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic [pss_pkg::BYTE_W-1:0]  out_byte,
    input logic                        run_last,
    input logic                        stream_end,
    input logic                        config_error
);
    import pss_pkg::*;

    // a waiting result holds until it is popped
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(run_last)
                              && $stable(stream_end) && $stable(config_error)))
        else $error("result changed while stalled");

    // the end of the stream is always the last byte of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && stream_end) |-> run_last)
        else $error("stream_end without run_last");

    // binary_mode reads back what was written
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[APB_AW-1:2] == REG_BINARY_MODE))
        |=> ((paddr[APB_AW-1:2] != REG_BINARY_MODE) || (prdata == APB_DW'($past(pwdata[0])))))
        else $error("binary_mode readback mismatch");

    // both queues come out of reset empty
    assert property (@(posedge clk) $rose(rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

endmodule

bind path_string_substitution_stream_top pss_checker u_pss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .stream_end   (stream_end),
    .config_error (config_error)
);

// ----- tb/sv/tb_path_string_substitution_stream_top.sv -----
// testbench: path substitution stream checked request by request against a rewrite predictor
`timescale 1ns / 1ps
module tb_path_string_substitution_stream_top;
    import pss_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 300;
    localparam int ITEMS_PER_SETTING = 10;
    localparam int MAX_RUN = PATH_MAX_BYTES + 1;

    typedef struct packed {
        logic [1:0]        op;
        logic [BYTE_W-1:0] value;
        logic [IDX_W-1:0]  index;
        logic              last;
    } request_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                push = 1'b0;
    logic                full;
    logic [1:0]          opcode = OP_DATA;
    logic [BYTE_W-1:0]   value_byte = '0;
    logic [IDX_W-1:0]    pattern_index = '0;
    logic                stream_last = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic [BYTE_W-1:0]   out_byte;
    logic                run_last;
    logic                stream_end;
    logic                config_error;

    // predictor state
    logic [BYTE_W-1:0]   old_path [PATH_MAX_BYTES];
    logic [BYTE_W-1:0]   new_path [PATH_MAX_BYTES];
    logic [BYTE_W-1:0]   held [PATH_MAX_BYTES];
    int                  held_n = 0;
    bit                  patching = 1'b0;
    bit                  mode_bin = 1'b0;
    int                  olen_reg = 1;
    int                  nlen_reg = 0;

    // stimulus side view of the old path and its length
    logic [BYTE_W-1:0]   stim_old [PATH_MAX_BYTES];
    int                  stim_olen = 1;

    request_t            pending_q [$];
    result_t             rewritten_q [$];
    int                  data_count = 0;
    int                  mismatches = 0;
    int                  idle_cycles = 0;
    int                  send_idle_pct = 29;
    int                  recv_idle_pct = 68;
    bit                  req_fire = 1'b0;

    path_string_substitution_stream_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .value_byte    (value_byte),
        .pattern_index (pattern_index),
        .stream_last   (stream_last),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .stream_end    (stream_end),
        .config_error  (config_error)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void drop_oldest_held();
        for (int i = 0; i < held_n - 1; i++)
            held[i] = held[i + 1];
        held_n--;
    endfunction

    function automatic void apply_register(input logic [REG_IDX_W-1:0] idx, input int value);
        case (idx)
            REG_BINARY_MODE: mode_bin = value[0];
            REG_OLD_LENGTH:  olen_reg = value & 63;
            REG_NEW_LENGTH:  nlen_reg = value & 63;
            default:         return;
        endcase
        // a write to any of the three registers drops held bytes and leaves the patched string
        held_n = 0;
        patching = 1'b0;
    endfunction

    task automatic rewrite_request(input request_t rq);
        logic [BYTE_W-1:0] bytes_out [$];
        result_t           res;
        int                olen;
        int                nlen;
        int                n;
        bit                err;
        bit                ok;
        if (rq.op == OP_LOAD_OLD)
        begin
            old_path[rq.index] = rq.value;
            return;
        end
        if (rq.op == OP_LOAD_NEW)
        begin
            new_path[rq.index] = rq.value;
            return;
        end
        if (rq.op != OP_DATA)
            return;
        olen = (olen_reg < 1) ? 1 : (olen_reg > PATH_MAX_BYTES) ? PATH_MAX_BYTES : olen_reg;
        nlen = (nlen_reg > PATH_MAX_BYTES) ? PATH_MAX_BYTES : nlen_reg;
        err = mode_bin && (nlen > olen);
        if (err)
        begin
            for (int i = 0; i < held_n; i++)
                bytes_out.push_back(held[i]);
            held_n = 0;
            bytes_out.push_back(rq.value);
            patching = 1'b0;
        end
        else if (mode_bin && patching)
        begin
            bytes_out.push_back(rq.value);
            if (rq.value == 8'h00 || rq.last)
            begin
                // stream end inside the string supplies the missing terminator
                if (rq.value != 8'h00)
                    bytes_out.push_back(8'h00);
                repeat (olen - nlen) bytes_out.push_back(8'h00);
                patching = 1'b0;
            end
        end
        else
        begin
            if (held_n == PATH_MAX_BYTES)
            begin
                bytes_out.push_back(held[0]);
                drop_oldest_held();
            end
            held[held_n] = rq.value;
            held_n++;
            while (held_n > 0)
            begin
                ok = (held_n <= olen);
                for (int i = 0; i < held_n && ok; i++)
                    if (held[i] != old_path[i])
                        ok = 1'b0;
                if (ok && held_n == olen)
                begin
                    for (int i = 0; i < nlen; i++)
                        bytes_out.push_back(new_path[i]);
                    held_n = 0;
                    if (mode_bin)
                        patching = 1'b1;
                    break;
                end
                if (ok)
                    break;
                bytes_out.push_back(held[0]);
                drop_oldest_held();
            end
            if (rq.last)
            begin
                if (patching)
                begin
                    bytes_out.push_back(8'h00);
                    repeat (olen - nlen) bytes_out.push_back(8'h00);
                    patching = 1'b0;
                end
                for (int i = 0; i < held_n; i++)
                    bytes_out.push_back(held[i]);
                held_n = 0;
            end
        end
        if (rq.last)
        begin
            held_n = 0;
            patching = 1'b0;
        end
        // the run is cut off after path length plus one bytes
        n = (bytes_out.size() > MAX_RUN) ? MAX_RUN : bytes_out.size();
        for (int k = 0; k < n; k++)
        begin
            res.data = bytes_out[k];
            res.run_last = (k == n - 1);
            res.stream_end = (k == n - 1) && rq.last;
            res.config_error = err;
            rewritten_q.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t mismatch on %s: expected %02h, got %02h", $realtime, field, want, got);
        mismatches++;
    endtask

    task automatic check_output();
        result_t want;
        if (rewritten_q.size() == 0)
        begin
            report_mismatch("unexpected out_byte", 8'h00, out_byte);
            return;
        end
        want = rewritten_q.pop_front();
        if (out_byte !== want.data)
            report_mismatch("out_byte", want.data, out_byte);
        if (run_last !== want.run_last)
            report_mismatch("run_last", 8'(want.run_last), 8'(run_last));
        if (stream_end !== want.stream_end)
            report_mismatch("stream_end", 8'(want.stream_end), 8'(stream_end));
        if (config_error !== want.config_error)
            report_mismatch("config_error", 8'(want.config_error), 8'(config_error));
    endtask

    // monitor: requests and results are taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_fire = push && !full;
            if (pop && !empty)
                check_output();
            if (req_fire)
                rewrite_request({opcode, value_byte, pattern_index, stream_last});
            if (req_fire || (pop && !empty))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // driver: request and pop change at the falling edge
    always @(negedge clk)
    begin
        request_t rq;
        if (rst_n)
        begin
            if (!push || req_fire)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    rq = pending_q.pop_front();
                    push <= 1'b1;
                    opcode <= rq.op;
                    value_byte <= rq.value;
                    pattern_index <= rq.index;
                    stream_last <= rq.last;
                end
                else
                    push <= 1'b0;
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic add_request(input logic [1:0] op, input logic [7:0] value,
                               input logic [4:0] index, input logic last);
        request_t rq;
        rq.op = op;
        rq.value = value;
        rq.index = index;
        rq.last = last;
        pending_q.push_back(rq);
    endtask

    task automatic add_data(input logic [7:0] value, input logic last);
        add_request(OP_DATA, value, '0, last);
        data_count++;
    endtask

    // small alphabet so that partial matches are common
    function automatic logic [7:0] path_char();
        case ($urandom_range(7))
            0, 1, 2: return 8'h2f;
            3, 4:    return 8'h61;
            5, 6:    return 8'h62;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic queue_stream();
        int segs;
        int plen;
        int idx;
        segs = $urandom_range(6, 1);
        for (int s = 0; s < segs; s++)
        begin
            case ($urandom_range(8))
                0, 1, 2:
                    for (int i = 0; i < stim_olen; i++)
                        add_data(stim_old[i], 1'b0);
                3:
                begin
                    // prefix of the old path broken by some other byte
                    plen = (stim_olen > 1) ? $urandom_range(stim_olen - 1, 1) : 1;
                    for (int i = 0; i < plen; i++)
                        add_data(stim_old[i], 1'b0);
                    add_data(path_char(), 1'b0);
                end
                4:
                    repeat ($urandom_range(3, 1)) add_data(path_char(), 1'b0);
                5:
                    add_data(8'h00, 1'b0);
                6:
                    add_data(8'($urandom_range(255)), 1'b0);
                7:
                    add_request(OP_NOP, 8'($urandom_range(255)), IDX_W'($urandom_range(31)),
                                1'($urandom_range(1)));
                default:
                begin
                    // rewrite an old path byte with its own value, stray last bit
                    idx = $urandom_range(PATH_MAX_BYTES - 1);
                    add_request(OP_LOAD_OLD, stim_old[idx], IDX_W'(idx),
                                1'($urandom_range(1)));
                end
            endcase
        end
        if ($urandom_range(9) != 0)
            add_data(path_char(), 1'b1);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        apply_register(idx, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // block is idle once every request is in, every result is out and held work is done
    task automatic settle();
        while (pending_q.size() > 0 || push)
            @(negedge clk);
        while (rewritten_q.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // both paths stay as loaded earlier, only binary_mode and the lengths change
    task automatic run_setting(input bit bin, input int olen, input int nlen);
        int start;
        settle();
        write_register(REG_BINARY_MODE, int'(bin));
        write_register(REG_OLD_LENGTH, olen);
        write_register(REG_NEW_LENGTH, nlen);
        stim_olen = olen;
        start = data_count;
        while (data_count - start < ITEMS_PER_SETTING)
            queue_stream();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // both paths fully written once so no unwritten byte is ever compared
        for (int i = 0; i < PATH_MAX_BYTES; i++)
        begin
            stim_old[i] = path_char();
            add_request(OP_LOAD_OLD, stim_old[i], IDX_W'(i), 1'b0);
            add_request(OP_LOAD_NEW, 8'($urandom_range(255)), IDX_W'(i), 1'b0);
        end

        // reset lengths: one byte deleted, so a lone match with last gives nothing
        add_data(stim_old[0], 1'b1);
        add_data(8'hff, 1'b0);
        add_data(8'h00, 1'b1);

        settle();
        write_register(REG_BINARY_MODE, 1);
        write_register(REG_OLD_LENGTH, 3);
        write_register(REG_NEW_LENGTH, 1);
        stim_olen = 3;
        stim_old[0] = 8'h2f;
        stim_old[1] = 8'h61;
        stim_old[2] = 8'h62;
        for (int i = 0; i < 3; i++)
            add_request(OP_LOAD_OLD, stim_old[i], IDX_W'(i), 1'b0);
        add_request(OP_LOAD_NEW, 8'h7a, 0, 1'b0);
        add_request(OP_LOAD_NEW, 8'hff, IDX_W'(PATH_MAX_BYTES - 1), 1'b1);
        // match, string tail, terminator with padding
        add_data(8'h2f, 1'b0);
        add_data(8'h61, 1'b0);
        add_data(8'h62, 1'b0);
        add_data(8'h63, 1'b0);
        add_data(8'h00, 1'b0);
        // partial match released
        add_data(8'h2f, 1'b0);
        add_data(8'h61, 1'b0);
        add_data(8'h78, 1'b0);
        // stream ends inside the patched string
        add_data(8'h2f, 1'b0);
        add_data(8'h61, 1'b0);
        add_data(8'h62, 1'b0);
        add_data(8'h71, 1'b1);
        // stream ends inside a held partial match
        add_data(8'h2f, 1'b0);
        add_data(8'h61, 1'b1);
        add_request(OP_NOP, 8'h5a, 5'h15, 1'b1);

        run_setting(0, 4, 7);
        run_setting(1, 8, 3);
        run_setting(1, 32, 0);

        settle();
        send_idle_pct = 68;
        recv_idle_pct = 29;
        run_setting(0, 32, 32);
        run_setting(1, 5, 5);
        run_setting(1, 3, 9);
        run_setting(0, 20, 17);

        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_setting(1, 1, 0);
        run_setting(0, 6, 2);
        run_setting(1'($urandom_range(1)), $urandom_range(PATH_MAX_BYTES, 1),
                    $urandom_range(PATH_MAX_BYTES));

        settle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
